### hdl/acfb_pkg.sv
// ============================================================================
// AES-128 CFB package
// Shared types, constants and AES round functions for the CFB stream cipher.
// ============================================================================
`default_nettype none

package acfb_pkg;

    localparam int SEG_BYTES_DEFAULT = 16;
    localparam int RK_DEPTH          = 11;
    localparam int RK_AW             = $clog2(RK_DEPTH);
    localparam int BLOCK_W           = 128;
    localparam int CFG_W             = 64;

    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [1:0] CFG_IV_HIGH  = 2'd2;
    localparam logic [1:0] CFG_IV_LOW   = 2'd3;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_INIT = 1'b1;

    typedef logic [0:15][7:0] t_block;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       encrypt;
        logic       message_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [16] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,
        8'h80,8'h1b,8'h36,8'h6c,8'hd8,8'hab,8'h4d,8'h9a
    };

    localparam logic [7:0] GF_POLY = 8'h1b;

    function automatic logic [7:0] xt(input logic [7:0] b);
        logic [7:0] s;
        s = {b[6:0], 1'b0};
        return b[7] ? (s ^ GF_POLY) : s;
    endfunction

    function automatic t_block aes_round(input t_block st, input logic last_round);
        t_block     t;
        logic [7:0] all;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[c*4+i] = SBOX[st[((c+i)%4)*4+i]];
            end
        end
        if (!last_round) begin
            for (int c = 0; c < 4; c++) begin
                a0  = t[c*4];
                a1  = t[c*4+1];
                a2  = t[c*4+2];
                a3  = t[c*4+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[c*4]   = a0 ^ all ^ xt(a0 ^ a1);
                t[c*4+1] = a1 ^ all ^ xt(a1 ^ a2);
                t[c*4+2] = a2 ^ all ^ xt(a2 ^ a3);
                t[c*4+3] = a3 ^ all ^ xt(a3 ^ a0);
            end
        end
        return t;
    endfunction

    function automatic t_block key_next(input t_block k, input logic [7:0] rc);
        t_block     n;
        logic [7:0] t [4];
        t[0] = SBOX[k[13]] ^ rc;
        t[1] = SBOX[k[14]];
        t[2] = SBOX[k[15]];
        t[3] = SBOX[k[12]];
        for (int j = 0; j < 4; j++) begin
            n[j]    = k[j] ^ t[j];
            n[4+j]  = k[4+j] ^ n[j];
            n[8+j]  = k[8+j] ^ n[4+j];
            n[12+j] = k[12+j] ^ n[8+j];
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### hdl/acfb_ram.sv
// ============================================================================
// Generic RAM
// Single write port, single read port with registered read data.
// ============================================================================
`default_nettype none

module acfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/aes128_cfb_stream_cipher.sv
// ============================================================================
// AES-128 CFB stream cipher
// Byte-wide CFB encryption and decryption with an iterative AES round unit.
// ============================================================================
// An init transfer expands the key one round key per cycle into an
// 11-entry round-key RAM and loads the feedback vector from the IV
// registers. On the first byte of each segment, a data transfer runs one
// AES round per cycle, with its round key read from the RAM, before it
// forms the output byte. A new transfer is taken only when the output
// register is empty or its result is read in the same cycle.
`default_nettype none

module aes128_cfb_stream_cipher #(
    parameter int SEGMENT_BYTES = acfb_pkg::SEG_BYTES_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [63:0]         i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire acfb_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output acfb_pkg::t_out_item      o_out
);

    import acfb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_KEY  = 4'b0010,
        ST_AES  = 4'b0100,
        ST_BYTE = 4'b1000
    } t_state;

    localparam logic [RK_AW-1:0] RK_LAST = RK_AW'(RK_DEPTH - 1);
    localparam logic [4:0]       SEG     = 5'(SEGMENT_BYTES);

    t_state           r_state, n_state;
    logic [63:0]      r_key_high, r_key_low, r_iv_high, r_iv_low;
    t_block           r_fv, n_fv;
    t_block           r_ks, n_ks;
    t_block           r_fill, n_fill;
    t_block           r_st, n_st;
    t_block           r_kw, n_kw;
    logic [3:0]       r_pos, n_pos;
    logic [RK_AW-1:0] r_round, n_round;
    t_in_item         r_in, n_in;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             accept;
    logic             rk_we;
    logic [RK_AW-1:0] rk_waddr, rk_raddr;
    logic [BLOCK_W-1:0] rk_wdata, rk_rdata;
    t_block           rk_blk;
    t_block           next_key;
    t_block           rnd_out;
    logic [7:0]       res;
    logic [4:0]       pos1;
    logic             close_seg;

    acfb_ram #(
        .WIDTH (BLOCK_W),
        .DEPTH (RK_DEPTH)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (rk_we),
        .i_waddr (rk_waddr),
        .i_wdata (rk_wdata),
        .i_raddr (rk_raddr),
        .o_rdata (rk_rdata)
    );

    assign rk_blk      = t_block'(rk_rdata);
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign next_key    = key_next(r_kw, RCON[r_round]);
    assign rnd_out     = aes_round(r_st, r_round == RK_LAST);

    always_comb begin
        rk_raddr = '0;
        if (r_state == ST_AES) begin
            rk_raddr = (r_round == RK_LAST) ? RK_LAST : r_round + 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fv        = r_fv;
        n_ks        = r_ks;
        n_fill      = r_fill;
        n_st        = r_st;
        n_kw        = r_kw;
        n_pos       = r_pos;
        n_round     = r_round;
        n_in        = r_in;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        rk_we       = 1'b0;
        rk_waddr    = r_round;
        rk_wdata    = next_key;
        res         = r_in.data_byte ^ r_ks[r_pos];
        pos1        = {1'b0, r_pos} + 5'd1;
        close_seg   = (pos1 >= SEG) || r_in.message_end;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_in = i_in;
                    if (i_in.command == CMD_INIT) begin
                        rk_we    = 1'b1;
                        rk_waddr = '0;
                        rk_wdata = {r_key_high, r_key_low};
                        n_kw     = t_block'({r_key_high, r_key_low});
                        n_fv     = t_block'({r_iv_high, r_iv_low});
                        n_pos    = '0;
                        n_round  = RK_AW'(1);
                        n_state  = ST_KEY;
                    end else if (r_pos == '0) begin
                        n_round = '0;
                        n_state = ST_AES;
                    end else begin
                        n_state = ST_BYTE;
                    end
                end
            end
            ST_KEY: begin
                rk_we   = 1'b1;
                n_kw    = next_key;
                n_round = r_round + 1'b1;
                if (r_round == RK_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_AES: begin
                n_round = r_round + 1'b1;
                if (r_round == '0) begin
                    n_st = r_fv ^ rk_blk;
                end else begin
                    n_st = rnd_out ^ rk_blk;
                end
                if (r_round == RK_LAST) begin
                    n_ks    = rnd_out ^ rk_blk;
                    n_state = ST_BYTE;
                end
            end
            ST_BYTE: begin
                n_out_valid       = 1'b1;
                n_out.out_byte    = res;
                n_out.last        = r_in.message_end;
                n_fill[r_pos]     = r_in.encrypt ? res : r_in.data_byte;
                n_pos             = pos1[3:0];
                if (close_seg) begin
                    for (int j = 0; j < 16; j++) begin
                        if (5'(j) >= pos1 && 5'(j) < SEG) begin
                            n_fill[j] = '0;
                        end
                    end
                    for (int j = 0; j < 16; j++) begin
                        if (j + SEGMENT_BYTES < 16) begin
                            n_fv[j] = r_fv[j + SEGMENT_BYTES];
                        end else begin
                            n_fv[j] = n_fill[j + SEGMENT_BYTES - 16];
                        end
                    end
                    n_pos = '0;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
            r_fv        <= '0;
            r_key_high  <= '0;
            r_key_low   <= '0;
            r_iv_high   <= '0;
            r_iv_low    <= '0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
            r_fv        <= n_fv;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                    CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    CFG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                    CFG_IV_LOW:   r_iv_low   <= i_cfg_data;
                    default:      r_iv_low   <= r_iv_low;
                endcase
            end
        end
        r_ks   <= n_ks;
        r_fill <= n_fill;
        r_st   <= n_st;
        r_kw   <= n_kw;
        r_in   <= n_in;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire
